@@ design/npcs_pkg.sv @@
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types, constants and helpers for the nearest palette color search.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;

    // front queue between the accepting side and the scan engine
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int COLOR_W = 8;
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 10;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic {
        OP_WRITE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [INDEX_W-1:0] idx;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic idle;
        logic finishing;
    } back_status_t;

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ design/npcs_front.sv @@
// ----------------------------------------------------------------------------
// npcs_front
// Accepts input transactions, drops out-of-range writes and queues the rest.
// ----------------------------------------------------------------------------
module npcs_front #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [npcs_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_blue,
    output logic                          q_valid,
    output npcs_pkg::item_t               q_item,
    input  logic                          q_pop
);

    localparam logic [npcs_pkg::INDEX_W:0] ENTRY_LIMIT = (npcs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

    npcs_pkg::item_t                    q_mem_reg [npcs_pkg::QUEUE_DEPTH];
    logic [npcs_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [npcs_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [npcs_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    npcs_pkg::item_t in_item;
    logic            in_keep;
    logic            push;
    logic            pop;

    always_comb begin
        in_item.op    = (s_command == npcs_pkg::CMD_QUERY) ? npcs_pkg::OP_QUERY
                                                           : npcs_pkg::OP_WRITE;
        in_item.idx   = s_entry_index;
        in_item.red   = s_red;
        in_item.green = s_green;
        in_item.blue  = s_blue;
        // writes past the end of the palette are taken and thrown away
        in_keep = (s_command == npcs_pkg::CMD_QUERY) ||
                  ({1'b0, s_entry_index} < ENTRY_LIMIT);
    end

    assign s_ready = (count_reg != npcs_pkg::QUEUE_CNT_W'(npcs_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready && in_keep;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == npcs_pkg::QUEUE_PTR_W'(npcs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == npcs_pkg::QUEUE_PTR_W'(npcs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ design/npcs_back.sv @@
// ----------------------------------------------------------------------------
// npcs_back
// Palette memory and scan engine; writes entries and answers nearest queries.
// ----------------------------------------------------------------------------
module npcs_back #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  npcs_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [npcs_pkg::INDEX_W-1:0]  m_best_index,
    output npcs_pkg::back_status_t        status
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);
    localparam int ENTRY_W = 3 * npcs_pkg::COLOR_W;

    npcs_pkg::state_t state_reg, state_next;

    logic [ENTRY_W-1:0]          mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0]  entry_vld_reg;

    logic [ADDR_W-1:0]           rd_addr_reg, rd_addr_next;
    logic                        issuing_reg, issuing_next;
    logic [ENTRY_W-1:0]          rd_data_reg;
    logic                        rd_ent_vld_reg;
    logic                        s1_vld_reg, s1_vld_next;
    logic                        s1_last_reg, s1_last_next;
    logic [ADDR_W-1:0]           s1_idx_reg, s1_idx_next;

    logic [npcs_pkg::COLOR_W-1:0] qry_r_reg, qry_g_reg, qry_b_reg;
    logic [ADDR_W-1:0]           best_idx_reg, best_idx_next;
    logic [npcs_pkg::DIST_W-1:0] best_dist_reg, best_dist_next;

    logic                        m_valid_reg, m_valid_next;
    logic [npcs_pkg::INDEX_W-1:0] m_best_index_reg;

    logic                        pop_write;
    logic                        pop_query;
    logic                        load_out;

    logic [ENTRY_W-1:0]          ent_color;
    logic [npcs_pkg::DIST_W-1:0] cand_dist;
    logic                        take_best;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            npcs_pkg::ST_IDLE: begin
                if (q_valid && q_item.op == npcs_pkg::OP_QUERY) begin
                    state_next = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN: begin
                if (s1_vld_reg && s1_last_reg) begin
                    state_next = npcs_pkg::ST_FINISH;
                end
            end
            npcs_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = npcs_pkg::ST_IDLE;
                end
            end
            default: state_next = npcs_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop     = 1'b0;
        pop_write = 1'b0;
        pop_query = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            npcs_pkg::ST_IDLE: begin
                q_pop     = q_valid;
                pop_write = q_valid && (q_item.op == npcs_pkg::OP_WRITE);
                pop_query = q_valid && (q_item.op == npcs_pkg::OP_QUERY);
            end
            npcs_pkg::ST_SCAN: begin
            end
            npcs_pkg::ST_FINISH: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // read address generation, one entry per cycle
    always_comb begin
        rd_addr_next = rd_addr_reg;
        issuing_next = issuing_reg;
        if (pop_query) begin
            rd_addr_next = '0;
            issuing_next = 1'b1;
        end else if (issuing_reg) begin
            if (rd_addr_reg == LAST_ADDR) begin
                issuing_next = 1'b0;
            end else begin
                rd_addr_next = rd_addr_reg + 1'b1;
            end
        end
        s1_vld_next  = issuing_reg && (state_reg == npcs_pkg::ST_SCAN);
        s1_last_next = (rd_addr_reg == LAST_ADDR);
        s1_idx_next  = rd_addr_reg;
    end

    // never-written entries read as black
    assign ent_color = rd_ent_vld_reg ? rd_data_reg : '0;

    always_comb begin
        cand_dist = npcs_pkg::DIST_W'(npcs_pkg::abs_diff(qry_r_reg, ent_color[23:16]))
                  + npcs_pkg::DIST_W'(npcs_pkg::abs_diff(qry_g_reg, ent_color[15:8]))
                  + npcs_pkg::DIST_W'(npcs_pkg::abs_diff(qry_b_reg, ent_color[7:0]));
        // entry zero seeds the search, later ones only win on strictly less
        take_best      = s1_vld_reg && ((s1_idx_reg == '0) || (cand_dist < best_dist_reg));
        best_idx_next  = take_best ? s1_idx_reg : best_idx_reg;
        best_dist_next = take_best ? cand_dist : best_dist_reg;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= npcs_pkg::ST_IDLE;
            issuing_reg   <= 1'b0;
            s1_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            entry_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            s1_vld_reg  <= s1_vld_next;
            m_valid_reg <= m_valid_next;
            if (pop_write) begin
                entry_vld_reg[q_item.idx[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg    <= rd_addr_next;
        s1_last_reg    <= s1_last_next;
        s1_idx_reg     <= s1_idx_next;
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        rd_ent_vld_reg <= entry_vld_reg[rd_addr_reg];
        if (pop_query) begin
            qry_r_reg <= q_item.red;
            qry_g_reg <= q_item.green;
            qry_b_reg <= q_item.blue;
        end
        if (load_out) begin
            m_best_index_reg <= npcs_pkg::INDEX_W'(best_idx_reg);
        end
    end

    // palette memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (pop_write) begin
            mem[q_item.idx[ADDR_W-1:0]] <= {q_item.red, q_item.green, q_item.blue};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    assign m_valid          = m_valid_reg;
    assign m_best_index     = m_best_index_reg;
    assign status.idle      = (state_reg == npcs_pkg::ST_IDLE);
    assign status.finishing = (state_reg == npcs_pkg::ST_FINISH);

endmodule

@@ design/nearest_palette_color_search.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with nearest-color (Manhattan distance) lookup.
// ----------------------------------------------------------------------------
// A transaction with command 0 writes one palette entry and returns nothing; a
// write whose index is at or past PALETTE_ENTRIES is accepted and dropped.
// A transaction with command 1 returns the lowest palette index at minimal
// |dr|+|dg|+|db| from the given color. Transactions that are kept go into a
// four-deep queue, so the input keeps taking items while a query runs, until the
// queue is full. The scan engine reads the palette through its single read port,
// one entry per cycle. A write only stores its entry; a query scans every entry and
// then waits for the previous result to be taken, if it is still held. The palette is
// black after reset through per-entry valid bits, so there is no clearing
// pass and the block is ready right after reset.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [npcs_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_blue,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [npcs_pkg::INDEX_W-1:0]  m_best_index
);

    localparam logic [npcs_pkg::INDEX_W:0] ENTRY_LIMIT = (npcs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

    logic                   q_valid;
    npcs_pkg::item_t        q_item;
    logic                   q_pop;
    npcs_pkg::back_status_t back_status;

    npcs_front #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry_index (s_entry_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    npcs_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_index (m_best_index),
        .status       (back_status)
    );

    // a result always names an entry inside the palette
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_best_index} < ENTRY_LIMIT))
        else $error("best index outside palette");

    // a new result only comes out of the finishing step of a scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(back_status.finishing))
        else $error("result raised outside scan completion");

    // the engine takes queued transactions only between scans
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_valid && back_status.idle))
        else $error("queue popped while engine busy");

    // a query pulled from the queue starts a scan on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.op == npcs_pkg::OP_QUERY) |=> !back_status.idle)
        else $error("query did not start a scan");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for nearest_palette_color_search. A shadow copy of the palette
// predicts the answer to every accepted query transaction. Each returned
// index is checked in order against that prediction. Directed corner cases
// run first. Random palette-write bursts and queries follow, under four
// sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 300;
    localparam int ITEMS_PER_MIX  = 458;
    localparam int ENTRIES        = npcs_pkg::PALETTE_ENTRIES;
    localparam int CW             = npcs_pkg::COLOR_W;
    localparam int IW             = npcs_pkg::INDEX_W;

    logic            aclk          = 1'b0;
    logic            aresetn       = 1'b0;
    logic            s_valid       = 1'b0;
    logic            s_ready;
    logic            s_command     = npcs_pkg::CMD_WRITE;
    logic [IW-1:0]   s_entry_index = '0;
    logic [CW-1:0]   s_red         = '0;
    logic [CW-1:0]   s_green       = '0;
    logic [CW-1:0]   s_blue        = '0;
    logic            m_valid;
    logic            m_ready       = 1'b0;
    logic [IW-1:0]   m_best_index;

    // shadow palette, {red, green, blue}, black after reset
    logic [3*CW-1:0] palette_shadow [ENTRIES];
    logic [IW-1:0]   pending_index_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int writes_sent    = 0;
    int queries_sent   = 0;
    int results_seen   = 0;

    nearest_palette_color_search DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_entry_index (s_entry_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_index  (m_best_index)
    );

    always #HALF_PERIOD aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("tb: errors");
        $finish;
    end

    // lowest index at the smallest |dr|+|dg|+|db|, ties keep the earlier entry
    function automatic logic [IW-1:0] nearest_entry(
        input logic [CW-1:0] r,
        input logic [CW-1:0] g,
        input logic [CW-1:0] b
    );
        logic [IW-1:0] winner;
        int            best_dist;
        int            dr, dg, db;
        winner    = '0;
        best_dist = 1 << 20;
        for (int k = 0; k < ENTRIES; k++) begin
            dr = int'(r) - int'(palette_shadow[k][3*CW-1:2*CW]);
            dg = int'(g) - int'(palette_shadow[k][2*CW-1:CW]);
            db = int'(b) - int'(palette_shadow[k][CW-1:0]);
            if (dr < 0) dr = -dr;
            if (dg < 0) dg = -dg;
            if (db < 0) db = -db;
            if (dr + dg + db < best_dist) begin
                best_dist = dr + dg + db;
                winner    = IW'(k);
            end
        end
        return winner;
    endfunction

    function automatic logic [CW-1:0] nudge(input logic [CW-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return CW'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // drive one transaction; when it is taken, update the shadow palette or queue the predicted index
    task automatic send_item(
        input npcs_pkg::op_t op,
        input logic [IW-1:0] idx,
        input logic [CW-1:0] r,
        input logic [CW-1:0] g,
        input logic [CW-1:0] b
    );
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_command     = (op == npcs_pkg::OP_QUERY) ? npcs_pkg::CMD_QUERY
                                                   : npcs_pkg::CMD_WRITE;
        s_entry_index = idx;
        s_red         = r;
        s_green       = g;
        s_blue        = b;
        do @(posedge aclk); while (!s_ready);
        if (op == npcs_pkg::OP_QUERY) begin
            pending_index_q.push_back(nearest_entry(r, g, b));
            queries_sent++;
        end else begin
            if (int'(idx) < ENTRIES) palette_shadow[idx] = {r, g, b};
            writes_sent++;
        end
    endtask

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_index_q.size() == 0) begin
                report_mismatch("result with no query pending", int'(m_best_index), 0);
            end else begin
                if (m_best_index !== pending_index_q[0])
                    report_mismatch("best_index", int'(m_best_index),
                                    int'(pending_index_q[0]));
                void'(pending_index_q.pop_front());
            end
        end
    end

    // black palette: every query ties everywhere and lands on entry zero
    task automatic test_reset_palette();
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::OP_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::OP_QUERY, 8'haa, 8'haa, 8'h55, 8'haa);
        send_item(npcs_pkg::OP_QUERY, 8'h55, 8'h55, 8'haa, 8'h55);
    endtask

    task automatic test_corner_cases();
        send_item(npcs_pkg::OP_WRITE, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'hc8, 8'hc8, 8'hc8);
        // white at both ends of the table, the low index must win
        send_item(npcs_pkg::OP_WRITE, 8'h00, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::OP_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
        send_item(npcs_pkg::OP_WRITE, 8'h80, 8'hff, 8'h00, 8'h80);
        send_item(npcs_pkg::OP_WRITE, 8'h40, 8'hff, 8'h00, 8'h80);
        send_item(npcs_pkg::OP_QUERY, 8'h12, 8'hfa, 8'h03, 8'h82);
        send_item(npcs_pkg::OP_WRITE, 8'h01, 8'h00, 8'hff, 8'h00);
        send_item(npcs_pkg::OP_WRITE, 8'h02, 8'h00, 8'h00, 8'hff);
        send_item(npcs_pkg::OP_WRITE, 8'h03, 8'hff, 8'h00, 8'h00);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'h10, 8'hf0, 8'h10);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'h00, 8'h00, 8'hfe);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'hfe, 8'h01, 8'h01);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::OP_QUERY, 8'hff, 8'h00, 8'h00, 8'h00);
        send_item(npcs_pkg::OP_QUERY, 8'h00, 8'h7f, 8'h80, 8'h7f);
    endtask

    // write bursts followed by queries at, near or away from stored colors, plus stray items
    task automatic test_random_traffic(input int n_items);
        int            sent;
        int            k;
        logic [CW-1:0] r, g, b;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                repeat ($urandom_range(8, 1)) begin
                    if ($urandom_range(9) == 0) begin
                        // copy an existing color to another slot to set up ties
                        k = $urandom_range(ENTRIES - 1);
                        {r, g, b} = palette_shadow[k];
                    end else begin
                        {r, g, b} = 24'($urandom);
                    end
                    send_item(npcs_pkg::OP_WRITE, IW'($urandom_range(255)), r, g, b);
                    sent++;
                end
                repeat ($urandom_range(3, 1)) begin
                    k = $urandom_range(ENTRIES - 1);
                    {r, g, b} = palette_shadow[k];
                    case ($urandom_range(2))
                        0: ;
                        1: begin
                            r = nudge(r);
                            g = nudge(g);
                            b = nudge(b);
                        end
                        default: {r, g, b} = 24'($urandom);
                    endcase
                    send_item(npcs_pkg::OP_QUERY, IW'($urandom_range(255)), r, g, b);
                    sent++;
                end
            end else begin
                send_item(npcs_pkg::op_t'($urandom_range(1)), IW'($urandom_range(255)),
                          CW'($urandom), CW'($urandom), CW'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        for (int k = 0; k < ENTRIES; k++) palette_shadow[k] = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_palette();
        test_corner_cases();

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(ITEMS_PER_MIX);
        send_idle_pct = 46; recv_stall_pct = 0;
        test_random_traffic(ITEMS_PER_MIX);
        send_idle_pct = 0;  recv_stall_pct = 46;
        test_random_traffic(ITEMS_PER_MIX);
        send_idle_pct = 32; recv_stall_pct = 32;
        test_random_traffic(ITEMS_PER_MIX);

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_index_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d palette writes and %0d queries accepted, %0d results checked",
                 writes_sent, queries_sent, results_seen);
        $display("summary: four idling mixes run, %0d mismatches", error_count);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
